>>> rtl/ltcm_pkg.sv
// Shared types, constants and helpers for the line trace cell marker.
`default_nettype none

package ltcm_pkg;

    localparam int COORD_W       = 6;
    localparam int DELTA_W       = COORD_W + 1;   // doubled delta
    localparam int ERR_W         = COORD_W + 3;   // signed error term
    localparam int GRID_SIDE_DEF = 64;

    typedef logic [COORD_W-1:0]       t_coord;
    typedef logic [DELTA_W-1:0]       t_delta;
    typedef logic signed [ERR_W-1:0]  t_err;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } t_state;

    // state handed to the step unit, in major/minor axis terms
    typedef struct packed {
        t_coord maj;
        t_coord min;
        logic   maj_pos;
        logic   min_pos;
        t_err   err;
        t_delta dmaj;
        t_delta dmin;
    } t_step_in;

    typedef struct packed {
        t_coord maj;
        t_coord min;
        t_err   err;
    } t_step_out;

    typedef struct packed {
        t_coord min_x;
        t_coord max_x;
        t_coord min_y;
        t_coord max_y;
    } t_box;

    function automatic t_coord clamp_coord(input t_coord v, input t_coord top);
        clamp_coord = (v > top) ? top : v;
    endfunction

    function automatic t_coord abs_diff(input t_coord a, input t_coord b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

>>> rtl/ltcm_step.sv
// Shared Bresenham step unit: one cell advance along the major axis.
`default_nettype none

module ltcm_step (
    input  var ltcm_pkg::t_step_in  i_step,
    output var ltcm_pkg::t_step_out o_step
);

    logic            minor_move;
    ltcm_pkg::t_err  sub_term;
    ltcm_pkg::t_err  add_term;

    always_comb begin
        // asymmetric tie-break: zero error steps only on positive major dir
        minor_move = (i_step.err > 0) || ((i_step.err == 0) && i_step.maj_pos);
        sub_term   = minor_move ? $signed({2'b00, i_step.dmaj}) : '0;
        add_term   = $signed({2'b00, i_step.dmin});
        o_step.err = i_step.err - sub_term + add_term;
        o_step.maj = i_step.maj_pos ? (i_step.maj + 1'b1) : (i_step.maj - 1'b1);
        if (minor_move) begin
            o_step.min = i_step.min_pos ? (i_step.min + 1'b1) : (i_step.min - 1'b1);
        end else begin
            o_step.min = i_step.min;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ltcm_box.sv
// Running bounding box of every emitted cell since reset.
`default_nettype none

module ltcm_box (
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var logic                i_upd,
    input  var ltcm_pkg::t_coord    i_x,
    input  var ltcm_pkg::t_coord    i_y,
    output var ltcm_pkg::t_box      o_box_next
);

    logic           r_valid;
    ltcm_pkg::t_box r_box;

    always_comb begin
        if (!r_valid) begin
            o_box_next = '{min_x: i_x, max_x: i_x, min_y: i_y, max_y: i_y};
        end else begin
            o_box_next.min_x = (i_x < r_box.min_x) ? i_x : r_box.min_x;
            o_box_next.max_x = (i_x > r_box.max_x) ? i_x : r_box.max_x;
            o_box_next.min_y = (i_y < r_box.min_y) ? i_y : r_box.min_y;
            o_box_next.max_y = (i_y > r_box.max_y) ? i_y : r_box.max_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_box   <= '0;
        end else if (i_upd) begin
            r_valid <= 1'b1;
            r_box   <= o_box_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/line_trace_cell_marker.sv
// Top level: ray tracer over a grid, one cell word out per cycle while tracing and not stalled.
//
// channel  dir  width  content
// -------  ---  -----  ------------------------------------------------
// s_axis   in   24     one ray: start cell and end cell
// m_axis   out  40+1+1 one visited cell, free or occupied, plus the box
//
// Sequence: a ray is taken in the idle state and passes a setup state, then
//   its |major delta| + 1 cells are emitted through the shared step unit;
//   the next ray is taken only after the last cell has been emitted.
// Stalls: a cell is produced only when the output register is empty or
//   being taken; back-pressure freezes the step unit.
// Reset: synchronous, active low; clears the sequencer, the output valid
//   and the bounding box.
`default_nettype none

module line_trace_cell_marker #(
    parameter int GRID_SIDE = ltcm_pkg::GRID_SIDE_DEF   // 2 .. 64
) (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    // input word
    input  var logic        i_s_axis_tvalid,
    output var logic        o_s_axis_tready,
    input  var logic [23:0] i_s_axis_tdata,   // start_x, start_y, end_x, end_y
    // output word
    output var logic        o_m_axis_tvalid,
    input  var logic        i_m_axis_tready,
    output var logic [39:0] o_m_axis_tdata,   // cell_x, cell_y, box_min_x,
                                              // box_max_x, box_min_y,
                                              // box_max_y, 4 zero bits
    output var logic        o_m_axis_tlast,   // last
    output var logic [0:0]  o_m_axis_tuser    // occupied
);

    localparam int CW = ltcm_pkg::COORD_W;
    localparam ltcm_pkg::t_coord TOP = CW'(GRID_SIDE - 1);

    // sequencer
    ltcm_pkg::t_state r_state, n_state;
    logic             in_accept;
    logic             out_free;
    logic             emit;
    logic             at_end;

    // latched ray (clamped)
    ltcm_pkg::t_coord r_sx, r_sy, r_ex, r_ey;

    // stepping state, major/minor view
    logic             r_x_major;
    ltcm_pkg::t_coord r_maj, r_min, r_maj_end;
    logic             r_maj_pos, r_min_pos;
    ltcm_pkg::t_err   r_err;
    ltcm_pkg::t_delta r_dmaj, r_dmin;

    // setup math
    ltcm_pkg::t_coord adx, ady, amaj, amin;
    logic             x_major;

    // shared step unit
    ltcm_pkg::t_step_in  step_in;
    ltcm_pkg::t_step_out step_out;

    // emitted cell and box
    ltcm_pkg::t_coord cell_x, cell_y;
    ltcm_pkg::t_box   box_next;

    // output register
    logic             r_out_valid;
    ltcm_pkg::t_coord r_out_x, r_out_y;
    logic             r_out_last;
    ltcm_pkg::t_box   r_out_box;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign at_end    = (r_maj == r_maj_end);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ltcm_pkg::ST_IDLE:  if (i_s_axis_tvalid) n_state = ltcm_pkg::ST_SETUP;
            ltcm_pkg::ST_SETUP: n_state = ltcm_pkg::ST_RUN;
            ltcm_pkg::ST_RUN:   if (out_free && at_end) n_state = ltcm_pkg::ST_IDLE;
            default:            n_state = ltcm_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        emit            = 1'b0;
        unique case (r_state)
            ltcm_pkg::ST_IDLE:  o_s_axis_tready = 1'b1;
            ltcm_pkg::ST_SETUP: emit = 1'b0;
            ltcm_pkg::ST_RUN:   emit = out_free;
            default:            o_s_axis_tready = 1'b0;
        endcase
    end

    // setup: absolute deltas and major axis; doubled deltas and initial error are registered in ST_SETUP
    always_comb begin
        adx     = ltcm_pkg::abs_diff(r_ex, r_sx);
        ady     = ltcm_pkg::abs_diff(r_ey, r_sy);
        x_major = (adx >= ady);
        amaj    = x_major ? adx : ady;
        amin    = x_major ? ady : adx;
    end

    always_comb begin
        step_in.maj     = r_maj;
        step_in.min     = r_min;
        step_in.maj_pos = r_maj_pos;
        step_in.min_pos = r_min_pos;
        step_in.err     = r_err;
        step_in.dmaj    = r_dmaj;
        step_in.dmin    = r_dmin;
    end

    ltcm_step u_step (
        .i_step (step_in),
        .o_step (step_out)
    );

    // the final word of a ray carries the end cell itself
    always_comb begin
        if (at_end) begin
            cell_x = r_ex;
            cell_y = r_ey;
        end else begin
            cell_x = r_x_major ? r_maj : r_min;
            cell_y = r_x_major ? r_min : r_maj;
        end
    end

    ltcm_box u_box (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_upd      (emit),
        .i_x        (cell_x),
        .i_y        (cell_y),
        .o_box_next (box_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ltcm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ray and stepping registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sx <= ltcm_pkg::clamp_coord(i_s_axis_tdata[CW-1:0], TOP);
            r_sy <= ltcm_pkg::clamp_coord(i_s_axis_tdata[2*CW-1:CW], TOP);
            r_ex <= ltcm_pkg::clamp_coord(i_s_axis_tdata[3*CW-1:2*CW], TOP);
            r_ey <= ltcm_pkg::clamp_coord(i_s_axis_tdata[4*CW-1:3*CW], TOP);
        end
        if (r_state == ltcm_pkg::ST_SETUP) begin
            r_x_major <= x_major;
            r_maj     <= x_major ? r_sx : r_sy;
            r_min     <= x_major ? r_sy : r_sx;
            r_maj_end <= x_major ? r_ex : r_ey;
            r_maj_pos <= x_major ? (r_ex > r_sx) : (r_ey > r_sy);
            r_min_pos <= x_major ? (r_ey > r_sy) : (r_ex > r_sx);
            r_dmaj    <= {amaj, 1'b0};
            r_dmin    <= {amin, 1'b0};
            r_err     <= $signed({2'b00, amin, 1'b0}) - $signed({3'b000, amaj});
        end else if (emit && !at_end) begin
            r_maj <= step_out.maj;
            r_min <= step_out.min;
            r_err <= step_out.err;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_x    <= cell_x;
            r_out_y    <= cell_y;
            r_out_last <= at_end;
            r_out_box  <= box_next;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_box.max_y, r_out_box.min_y,
                              r_out_box.max_x, r_out_box.min_x, r_out_y, r_out_x};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_last;

`ifndef SYNTHESIS
    // every emitted cell lies inside the box reported with it
    a_cell_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_box.min_x <= r_out_x) && (r_out_x <= r_out_box.max_x)
                     && (r_out_box.min_y <= r_out_y) && (r_out_y <= r_out_box.max_y))
        else $error("emitted cell outside bounding box");

    // a new ray always passes through setup first
    a_accept_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ltcm_pkg::ST_SETUP))
        else $error("accepted ray did not enter setup");

    // the last word of a ray is the clamped end cell
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && at_end |=> (r_out_x == r_ex) && (r_out_y == r_ey) && r_out_last)
        else $error("final word is not the end cell");

    // no input taken while a cell is still being produced
    a_no_accept_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !o_s_axis_tready)
        else $error("input ready while tracing");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_line_trace_cell_marker.sv
// Testbench for line_trace_cell_marker: directed and random rays checked cell by cell.
module tb_line_trace_cell_marker;

    // grid size of the instance below (the block's default)
    localparam int GRID       = ltcm_pkg::GRID_SIDE_DEF;
    // cycles with no word moving on either side before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    // longest gap the sender inserts before one ray
    localparam int MAX_GAP    = 20;
    // wait after the last expected cell: a full ray plus setup
    localparam int DRAIN_WAIT = 80;

    // one expected output word
    typedef struct {
        ltcm_pkg::t_coord cell_x;
        ltcm_pkg::t_coord cell_y;
        logic             occupied;
        logic             last;
        ltcm_pkg::t_box   box;
    } t_cell_word;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata  = '0;   // start_x, start_y, end_x, end_y
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b1;
    logic [39:0] o_m_axis_tdata;         // cell_x, cell_y, box_min_x, box_max_x,
                                         // box_min_y, box_max_y, 4 zero bits
    logic        o_m_axis_tlast;         // last
    logic [0:0]  o_m_axis_tuser;         // occupied

    // expected cells in emission order, filled when a ray is accepted
    t_cell_word pending_cells[$];

    // running bounding box as the block should hold it
    bit             box_seen;
    ltcm_pkg::t_box box_now;

    // idling knobs, percent per cycle
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    line_trace_cell_marker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // out-of-grid coordinates saturate to the last row/column
    function automatic int clamp_to_grid(input logic [5:0] v);
        return (int'(v) > GRID - 1) ? GRID - 1 : int'(v);
    endfunction

    // grow the box by one emitted cell and queue the word we expect
    function automatic void mark_cell(input int x, input int y, input logic occ,
                                      input logic last);
        t_cell_word c;
        c.cell_x = ltcm_pkg::t_coord'(x);
        c.cell_y = ltcm_pkg::t_coord'(y);
        if (!box_seen) begin
            // first cell since reset pins all four limits
            box_now  = '{min_x: c.cell_x, max_x: c.cell_x,
                         min_y: c.cell_y, max_y: c.cell_y};
            box_seen = 1'b1;
        end else begin
            if (c.cell_x < box_now.min_x) box_now.min_x = c.cell_x;
            if (c.cell_x > box_now.max_x) box_now.max_x = c.cell_x;
            if (c.cell_y < box_now.min_y) box_now.min_y = c.cell_y;
            if (c.cell_y > box_now.max_y) box_now.max_y = c.cell_y;
        end
        c.occupied = occ;
        c.last     = last;
        c.box      = box_now;
        pending_cells.push_back(c);
    endfunction

    // Bresenham walk on doubled deltas. Ties (error exactly zero) step the
    // minor axis only when the major direction is positive.
    function automatic void trace_ray(input logic [23:0] ray);
        int x, y, ex, ey, sx, sy, dx, dy, err, n;
        x  = clamp_to_grid(ray[5:0]);
        y  = clamp_to_grid(ray[11:6]);
        ex = clamp_to_grid(ray[17:12]);
        ey = clamp_to_grid(ray[23:18]);
        sx = (ex > x) ? 1 : ((ex < x) ? -1 : 0);
        sy = (ey > y) ? 1 : ((ey < y) ? -1 : 0);
        dx = 2 * ((ex > x) ? ex - x : x - ex);
        dy = 2 * ((ey > y) ? ey - y : y - ey);
        n  = 0;
        if (dx >= dy) begin
            err = dy - (dx >>> 1);
            while (x != ex && n < GRID - 1) begin
                mark_cell(x, y, 1'b0, 1'b0);
                n++;
                if (err > 0 || (err == 0 && sx > 0)) begin
                    err -= dx;
                    y   += sy;
                end
                err += dy;
                x   += sx;
            end
        end else begin
            err = dx - (dy >>> 1);
            while (y != ey && n < GRID - 1) begin
                mark_cell(x, y, 1'b0, 1'b0);
                n++;
                if (err > 0 || (err == 0 && sy > 0)) begin
                    err -= dy;
                    x   += sx;
                end
                err += dx;
                y   += sy;
            end
        end
        // the end cell is the obstacle: occupied and closes the run
        mark_cell(ex, ey, 1'b1, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what,
                 got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // every accepted cell word is compared against the oldest expectation
    always @(posedge i_clk) begin : cell_checker
        t_cell_word want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_cells.size() == 0) begin
                report_mismatch("unexpected cell word", o_m_axis_tdata[7:0], 8'h0);
            end else begin
                want = pending_cells.pop_front();
                check_field("cell_x",    o_m_axis_tdata[5:0],   want.cell_x);
                check_field("cell_y",    o_m_axis_tdata[11:6],  want.cell_y);
                check_field("box_min_x", o_m_axis_tdata[17:12], want.box.min_x);
                check_field("box_max_x", o_m_axis_tdata[23:18], want.box.max_x);
                check_field("box_min_y", o_m_axis_tdata[29:24], want.box.min_y);
                check_field("box_max_y", o_m_axis_tdata[35:30], want.box.max_y);
                check_field("pad bits",  o_m_axis_tdata[39:36], 8'h0);
                check_field("last",      o_m_axis_tlast,        want.last);
                check_field("occupied",  o_m_axis_tuser,        want.occupied);
            end
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk)
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // hang detector: nothing moving on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                     || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic logic [23:0] pack_ray(input int sx, input int sy, input int ex,
                                             input int ey);
        return {ltcm_pkg::t_coord'(ey), ltcm_pkg::t_coord'(ex),
                ltcm_pkg::t_coord'(sy), ltcm_pkg::t_coord'(sx)};
    endfunction

    // Present one ray and hold it until taken. Called at a rising edge; valid
    // stays high into the next ray unless a gap is drawn.
    task automatic send_ray(input logic [23:0] ray);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ray;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        trace_ray(ray);
    endtask

    // single-cell rays; the very first one also seeds the box
    task automatic test_single_cell_rays();
        send_ray(pack_ray(30, 30, 30, 30));
        send_ray(pack_ray(0, 0, 0, 0));
        send_ray(pack_ray(63, 63, 63, 63));
    endtask

    // full-length straight rays in every direction, two diagonals, short and near-axis rays
    task automatic test_straight_rays();
        send_ray(pack_ray(0, 0, 63, 0));
        send_ray(pack_ray(63, 63, 0, 63));
        send_ray(pack_ray(0, 0, 0, 63));
        send_ray(pack_ray(63, 63, 63, 0));
        send_ray(pack_ray(0, 0, 63, 63));
        send_ray(pack_ray(63, 0, 0, 63));
        send_ray(pack_ray(5, 5, 6, 5));
        send_ray(pack_ray(6, 5, 5, 5));
        send_ray(pack_ray(0, 31, 63, 32));
        send_ray(pack_ray(40, 0, 41, 63));
    endtask

    // rays whose error hits zero: the tie resolves by major direction
    task automatic test_tie_rays();
        send_ray(pack_ray(10, 10, 12, 11));
        send_ray(pack_ray(12, 11, 10, 10));
        send_ray(pack_ray(12, 10, 10, 11));
        send_ray(pack_ray(20, 20, 21, 22));
        send_ray(pack_ray(21, 22, 20, 20));
        send_ray(pack_ray(21, 20, 20, 22));
        send_ray(pack_ray(0, 63, 6, 60));
    endtask

    // random rays: mostly uniform, plus short, straight, diagonal and single-cell ones
    task automatic test_random_rays(input int count, input int unsigned idle,
                                    input int unsigned stall);
        int sx, sy, ex, ey, len;
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (count) begin
            sx = $urandom_range(63);
            sy = $urandom_range(63);
            case ($urandom_range(9))
                6, 7: begin
                    ex = sx + $urandom_range(6) - 3;
                    ey = sy + $urandom_range(6) - 3;
                    ex = (ex < 0) ? 0 : ((ex > 63) ? 63 : ex);
                    ey = (ey < 0) ? 0 : ((ey > 63) ? 63 : ey);
                end
                8: begin
                    len = $urandom_range(63);
                    case ($urandom_range(2))
                        0:       begin ex = len; ey = sy;  end
                        1:       begin ex = sx;  ey = len; end
                        default: begin
                            // diagonal from a corner region
                            sx = $urandom_range(1) ? 0 : 63;
                            sy = $urandom_range(1) ? 0 : 63;
                            ex = (sx == 0) ? len : 63 - len;
                            ey = (sy == 0) ? len : 63 - len;
                        end
                    endcase
                end
                9: begin
                    ex = sx;
                    ey = sy;
                end
                default: begin
                    ex = $urandom_range(63);
                    ey = $urandom_range(63);
                end
            endcase
            send_ray(pack_ray(sx, sy, ex, ey));
        end
    endtask

    initial begin
        box_seen = 1'b0;
        box_now  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_cell_rays();
        test_straight_rays();
        test_tie_rays();
        test_random_rays(26, 0, 0);
        test_random_rays(28, 53, 0);
        test_random_rays(28, 0, 53);
        test_random_rays(28, 26, 26);

        i_s_axis_tvalid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> line_trace_cell_marker.f
rtl/ltcm_pkg.sv
rtl/ltcm_step.sv
rtl/ltcm_box.sv
rtl/line_trace_cell_marker.sv
tb/sv/tb_line_trace_cell_marker.sv
